// ===== rtl/core/shipp_pkg.sv =====
`default_nettype none

package shipp_pkg;

  // default geometry
  localparam int unsigned DEF_SETS        = 1024;
  localparam int unsigned DEF_WAYS        = 16;
  localparam int unsigned DEF_SIG_BITS    = 14;
  localparam int unsigned DEF_COUNTER_MAX = 7;

  // re-reference values
  localparam int unsigned RRV_W = 2;
  localparam logic [RRV_W-1:0] RR_DISTANT = 2'd3;
  localparam logic [RRV_W-1:0] RR_LONG    = 2'd2;
  localparam logic [RRV_W-1:0] RR_NEAR    = 2'd0;

  // command and access kind codes
  localparam logic       CMD_VICTIM     = 1'b0;
  localparam logic [1:0] KIND_PREFETCH  = 2'd1;
  localparam logic [1:0] KIND_WRITEBACK = 2'd2;

  // sequencer states
  typedef enum logic [4:0] {
    S_CLR  = 5'b00001,
    S_IDLE = 5'b00010,
    S_RED  = 5'b00100,
    S_RD   = 5'b01000,
    S_MOD  = 5'b10000
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/core/shipp_victim_sel.sv =====
`default_nettype none

module shipp_victim_sel import shipp_pkg::*; #(
  parameter int unsigned WAYS = DEF_WAYS
) (
  input  logic [RRV_W*WAYS-1:0]   rrv_i,
  output logic [RRV_W*WAYS-1:0]   aged_o,
  output logic [$clog2(WAYS)-1:0] pick_o
);

  localparam int unsigned WAY_W = $clog2(WAYS);

  logic [3:0]       seen;
  logic [RRV_W-1:0] top;
  logic [RRV_W-1:0] gain;

  always_comb begin
    seen = '0;
    for (int unsigned w = 0; w < WAYS; w++) begin
      seen[rrv_i[w*RRV_W +: RRV_W]] = 1'b1;
    end
    if (seen[3]) begin
      top = 2'd3;
    end else if (seen[2]) begin
      top = 2'd2;
    end else if (seen[1]) begin
      top = 2'd1;
    end else begin
      top = 2'd0;
    end
    gain = RR_DISTANT - top;
    // lowest way holding the top value wins
    pick_o = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (rrv_i[w*RRV_W +: RRV_W] == top) begin
        pick_o = WAY_W'(w);
      end
    end
    for (int unsigned w = 0; w < WAYS; w++) begin
      aged_o[w*RRV_W +: RRV_W] = rrv_i[w*RRV_W +: RRV_W] + gain;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/signature_rrip_replacement_top.sv =====
`default_nettype none

// Signature-based RRIP replacement (SHiP++ style). One memory holds a row per
// set with each way's 2-bit re-reference value, reused flag, prefetched flag
// and signature; a second holds the saturating signature counters. cmd 0 asks
// for a victim: the first way at the set's highest value is returned on
// evict_way_o and the whole set is aged so that value reaches distant. cmd 1
// is an update after a hit or a fill and returns no beat; an update whose way
// is not below WAYS changes nothing. After reset a clearing pass over
// max(SETS, 2**SIG_BITS) addresses runs with in_ready_o low. A victim request
// then passes accept (set quotient), set reduction with the row and
// new-signature counter read, and read data back with the victim write; an
// update takes the same steps, reading the old-signature counter in read-back,
// then writes back, a step it skips when its way is out of range. The
// registered row-memory read and the counter read that depends on the stored
// signature set these steps; one item is in flight at a time. A finished
// victim beat sits in an output register and does not hold up the next accept;
// a following victim request waits in read-back while that beat is unaccepted.

module signature_rrip_replacement_top import shipp_pkg::*; #(
  parameter int unsigned SETS        = DEF_SETS,
  parameter int unsigned WAYS        = DEF_WAYS,
  parameter int unsigned SIG_BITS    = DEF_SIG_BITS,
  parameter int unsigned COUNTER_MAX = DEF_COUNTER_MAX
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       cmd_i,
  input  logic [9:0] set_index_i,
  input  logic [3:0] way_i,
  input  logic [9:0] pc_low_i,
  input  logic [1:0] access_kind_i,
  input  logic       hit_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] evict_way_o
);

  localparam int unsigned SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WAY_W  = $clog2(WAYS);
  localparam int unsigned CTR_W  = $clog2(COUNTER_MAX + 1);
  localparam int unsigned SIG_N  = 1 << SIG_BITS;
  localparam int unsigned EW     = SIG_BITS + 4;        // {sig, pf, reused, rrv}
  localparam int unsigned ROW_W  = WAYS * EW;
  localparam int unsigned CLR_N  = (SETS > SIG_N) ? SETS : SIG_N;
  localparam int unsigned CLR_W  = $clog2(CLR_N);
  localparam int unsigned RED_SH = 20;
  localparam int unsigned RECIP  = (1 << RED_SH) / SETS;

  localparam logic [CTR_W-1:0] CTR_MAX   = CTR_W'(COUNTER_MAX);
  localparam logic [ROW_W-1:0] RESET_ROW = {WAYS{EW'(RR_LONG)}};

  // storage
  logic [ROW_W-1:0] line_mem [SETS];
  logic [CTR_W-1:0] ctr_mem  [SIG_N];

  state_e state_q, state_d;
  logic [CLR_W-1:0] clr_q;

  // captured beat
  logic                cmd_q;
  logic [3:0]          way_q;
  logic [9:0]          pc_q;
  logic [1:0]          kind_q;
  logic                hit_q;
  logic [9:0]          set_in_q;
  logic [9:0]          quo_q;
  logic [SET_W-1:0]    set_q;

  logic [ROW_W-1:0]    row_q;
  logic [CTR_W-1:0]    ctr_rd_q;
  logic [CTR_W-1:0]    ctr_new_q;

  logic                out_valid_q, out_valid_d;
  logic [3:0]          victim_q, victim_d;

  // memory port controls
  logic                line_re, line_we;
  logic [SET_W-1:0]    line_waddr;
  logic [ROW_W-1:0]    line_wdata;
  logic                ctr_re, ctr_we;
  logic [SIG_BITS-1:0] ctr_raddr, ctr_waddr;
  logic [CTR_W-1:0]    ctr_wdata;

  logic                accept;
  logic                out_free;

  // set reduction
  logic [31:0]         quo_prod;
  logic [31:0]         rem_raw, rem_fix;
  logic [SET_W-1:0]    set_red;

  // signatures and the addressed entry
  logic                is_pf, is_wb;
  logic [31:0]         sig_full;
  logic [SIG_BITS-1:0] new_sig, old_sig;
  logic                way_ok;
  logic [WAY_W-1:0]    way_idx;
  logic [EW-1:0]       ent, ent_nx;
  logic                e_reu, e_pf, n_pf;
  logic [RRV_W-1:0]    e_rrv, n_rrv;
  logic [CTR_W-1:0]    ctr_old_nx, c_ins;
  logic [ROW_W-1:0]    upd_row, vic_row;

  // victim selection
  logic [RRV_W*WAYS-1:0] rrv_vec, aged_vec;
  logic [WAY_W-1:0]      pick;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;

  // quotient estimate from the reciprocal; low by at most one
  assign quo_prod = (32'(set_index_i) * 32'(RECIP)) >> RED_SH;
  assign rem_raw  = 32'(set_in_q) - 32'(quo_q) * 32'(SETS);
  assign rem_fix  = (rem_raw >= 32'(SETS)) ? rem_raw - 32'(SETS) : rem_raw;
  assign set_red  = rem_fix[SET_W-1:0];

  assign is_pf    = (kind_q == KIND_PREFETCH);
  assign is_wb    = (kind_q == KIND_WRITEBACK);
  assign sig_full = {18'd0, pc_q, 4'd0} | (is_pf ? 32'd4 : 32'd0);
  assign new_sig  = sig_full[SIG_BITS-1:0];

  assign way_ok   = (32'(way_q) < 32'(WAYS));
  assign way_idx  = WAY_W'(way_q);
  assign ent      = row_q[way_idx*EW +: EW];
  assign e_rrv    = ent[1:0];
  assign e_reu    = ent[2];
  assign e_pf     = ent[3];
  assign old_sig  = ent[EW-1:4];

  always_comb begin
    for (int unsigned w = 0; w < WAYS; w++) begin
      rrv_vec[w*RRV_W +: RRV_W] = row_q[w*EW +: RRV_W];
    end
    vic_row = row_q;
    for (int unsigned w = 0; w < WAYS; w++) begin
      vic_row[w*EW +: RRV_W] = aged_vec[w*RRV_W +: RRV_W];
    end
  end

  shipp_victim_sel #(
    .WAYS (WAYS)
  ) u_victim_sel (
    .rrv_i  (rrv_vec),
    .aged_o (aged_vec),
    .pick_o (pick)
  );

  // line and counter update for cmd 1
  always_comb begin
    ctr_old_nx = ctr_rd_q;
    n_pf       = e_pf;
    n_rrv      = e_rrv;
    c_ins      = ctr_new_q;
    if (hit_q) begin
      if (!e_reu) begin
        if (e_pf) begin
          n_pf = 1'b0;
        end else if (ctr_rd_q != CTR_MAX) begin
          ctr_old_nx = ctr_rd_q + CTR_W'(1);
        end
      end
      if (!n_pf && e_rrv != RR_NEAR) begin
        n_rrv = e_rrv - RRV_W'(1);
      end
      ent_nx = {old_sig, n_pf, 1'b1, n_rrv};
    end else begin
      if (!e_reu && ctr_rd_q != '0) begin
        ctr_old_nx = ctr_rd_q - CTR_W'(1);
      end
      // same signature: the insertion sees the just-trained count
      c_ins = (old_sig == new_sig) ? ctr_old_nx : ctr_new_q;
      if (is_wb || c_ins == '0) begin
        n_rrv = RR_DISTANT;
      end else if (c_ins == CTR_MAX) begin
        n_rrv = RR_NEAR;
      end else begin
        n_rrv = RR_LONG;
      end
      ent_nx = {new_sig, is_pf, 1'b0, n_rrv};
    end
    upd_row = row_q;
    upd_row[way_idx*EW +: EW] = ent_nx;
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    line_re     = 1'b0;
    line_we     = 1'b0;
    line_waddr  = set_q;
    line_wdata  = upd_row;
    ctr_re      = 1'b0;
    ctr_raddr   = old_sig;
    ctr_we      = 1'b0;
    ctr_waddr   = old_sig;
    ctr_wdata   = ctr_old_nx;
    out_valid_d = out_valid_q && !out_ready_i;
    victim_d    = victim_q;
    case (state_q)
      S_CLR: begin
        line_we    = (32'(clr_q) < 32'(SETS));
        line_waddr = SET_W'(clr_q);
        line_wdata = RESET_ROW;
        ctr_we     = (32'(clr_q) < 32'(SIG_N));
        ctr_waddr  = SIG_BITS'(clr_q);
        ctr_wdata  = '0;
        if (32'(clr_q) == 32'(CLR_N - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_RED;
        end
      end
      S_RED: begin
        line_re   = 1'b1;
        ctr_re    = 1'b1;
        ctr_raddr = new_sig;
        state_d   = S_RD;
      end
      S_RD: begin
        if (cmd_q == CMD_VICTIM) begin
          if (out_free) begin
            line_we     = 1'b1;
            line_wdata  = vic_row;
            out_valid_d = 1'b1;
            victim_d    = 4'(pick);
            state_d     = S_IDLE;
          end
        end else if (way_ok) begin
          ctr_re  = 1'b1;
          state_d = S_MOD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_MOD: begin
        line_we = 1'b1;
        ctr_we  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (state_q == S_CLR) begin
        clr_q <= clr_q + CLR_W'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    victim_q <= victim_d;
    if (accept) begin
      cmd_q    <= cmd_i;
      way_q    <= way_i;
      pc_q     <= pc_low_i;
      kind_q   <= access_kind_i;
      hit_q    <= hit_i;
      set_in_q <= set_index_i;
      quo_q    <= quo_prod[9:0];
    end
    if (state_q == S_RED) begin
      set_q <= set_red;
    end
    if (state_q == S_RD) begin
      ctr_new_q <= ctr_rd_q;
    end
  end

  // set row memory
  always_ff @(posedge clk_i) begin
    if (line_we) begin
      line_mem[line_waddr] <= line_wdata;
    end
    if (line_re) begin
      row_q <= line_mem[set_red];
    end
  end

  // signature counter memory
  always_ff @(posedge clk_i) begin
    if (ctr_we) begin
      ctr_mem[ctr_waddr] <= ctr_wdata;
    end
    if (ctr_re) begin
      ctr_rd_q <= ctr_mem[ctr_raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign evict_way_o = victim_q;

endmodule

`default_nettype wire
